@@ src/wpd_pkg.sv @@
// Package for the waveform plot decimator: command codes, register indexes,
// sequencer states and the divider status bundle. No dependencies.
package wpd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SCALE_W = 16;
   localparam int RES_W = 8;
   localparam int CH_REG_W = 4;
   localparam int START_W = 24;
   localparam int REG_IDX_W = 3;

   // Shifts that divide by the 8-bit range (0x100) and the 16-bit range (0x10000).
   localparam logic [4:0] NARROW_SHIFT = 5'd8;
   localparam logic [4:0] WIDE_SHIFT = 5'd16;

   localparam logic [1:0] CMD_MOVE = 2'd0;
   localparam logic [1:0] CMD_LINE = 2'd1;
   localparam logic [1:0] CMD_FILL = 2'd2;

   localparam logic [REG_IDX_W-1:0] REG_CHANNELS = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SAMPLE_MODE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_PLOT_WIDTH = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_PLOT_HEIGHT = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SCALE = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_RESOLUTION = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_START_FRAME = 3'd6;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_DIV_INC = 8'b0000_0010,
      ST_DIV_AVG = 8'b0000_0100,
      ST_MUL     = 8'b0000_1000,
      ST_SCALE   = 8'b0001_0000,
      ST_LINE    = 8'b0010_0000,
      ST_FINISH  = 8'b0100_0000,
      ST_MOVE    = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ src/wpd_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on wpd_pkg for the status bundle.
module wpd_div #(
   parameter int DIVIDEND_W = 20,
   parameter int DIVISOR_W = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DIVIDEND_W-1:0]      dividend,
   input  logic [DIVISOR_W-1:0]       divisor,
   output wpd_pkg::div_status_type    status,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff = trial - {1'b0, divisor_ff};
      fits = trial >= {1'b0, divisor_ff};
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in = rem_ff;
      quo_in = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         count_in = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
         rem_in = '0;
         quo_in = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/waveform_plot_decimator.sv @@
// Top level of the waveform plot decimator: register file, sequencer and result register.
// Depends on wpd_pkg and on the shared divider wpd_div.

// A start transaction loads a move result when the plot width and height are
// both non-zero. A sample transaction that does not complete a drawn frame
// leaves the sequencer idle, or passes to the finish state when it ends the
// buffer. A drawn frame runs the single bit-serial divider twice, once for
// the frame step scale/resolution and once for the channel average, on
// DIVIDEND_W-bit dividends (DIVIDEND_W = 17 + log2(MAX_CHANNELS), 20 at the
// defaults), followed by the multiply, scaling and line states; the line state
// waits for the result register to drain and passes to the finish state when
// the sample ends the buffer. A frame that falls on a full display divides once.
// The block takes no new transaction while a sample is in work.
module waveform_plot_decimator #(
   parameter int MAX_CHANNELS = 8,
   parameter int DIM_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [wpd_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                          req_end_of_buffer,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_command,
   output logic [DIM_BITS-1:0]           rsp_pos_x,
   output logic [DIM_BITS-1:0]           rsp_pos_y,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [4:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   localparam int CH_IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int SUM_W = wpd_pkg::SAMPLE_W + 1 + CH_IDX_W;
   localparam int AVG_W = wpd_pkg::SAMPLE_W + 1;
   localparam int PROD_W = AVG_W + DIM_BITS + 1;
   localparam int PIX_W = wpd_pkg::SCALE_W + 1;
   localparam int RES_W = wpd_pkg::RES_W;
   localparam int START_W = wpd_pkg::START_W;

   // Configuration registers.
   logic [wpd_pkg::CH_REG_W-1:0]   channels_ff;
   logic                           sample_mode_ff;
   logic [DIM_BITS-1:0]            plot_width_ff;
   logic [DIM_BITS-1:0]            plot_height_ff;
   logic [wpd_pkg::SCALE_W-1:0]    scale_ff;
   logic [RES_W-1:0]               resolution_ff;
   logic [START_W-1:0]             start_frame_ff;
   logic                           csr_write;
   logic [wpd_pkg::REG_IDX_W-1:0]  reg_idx;

   assign csr_write = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         channels_ff <= wpd_pkg::CH_REG_W'(1);
         sample_mode_ff <= 1'b0;
         plot_width_ff <= '0;
         plot_height_ff <= '0;
         scale_ff <= wpd_pkg::SCALE_W'(16);
         resolution_ff <= RES_W'(8);
         start_frame_ff <= '0;
      end else if (csr_write) begin
         case (reg_idx)
            wpd_pkg::REG_CHANNELS: channels_ff <= pwdata[wpd_pkg::CH_REG_W-1:0];
            wpd_pkg::REG_SAMPLE_MODE: sample_mode_ff <= pwdata[0];
            wpd_pkg::REG_PLOT_WIDTH: plot_width_ff <= pwdata[DIM_BITS-1:0];
            wpd_pkg::REG_PLOT_HEIGHT: plot_height_ff <= pwdata[DIM_BITS-1:0];
            wpd_pkg::REG_SCALE: scale_ff <= pwdata[wpd_pkg::SCALE_W-1:0];
            wpd_pkg::REG_RESOLUTION: resolution_ff <= pwdata[RES_W-1:0];
            wpd_pkg::REG_START_FRAME: start_frame_ff <= pwdata[START_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         wpd_pkg::REG_CHANNELS: prdata = 32'(channels_ff);
         wpd_pkg::REG_SAMPLE_MODE: prdata = 32'(sample_mode_ff);
         wpd_pkg::REG_PLOT_WIDTH: prdata = 32'(plot_width_ff);
         wpd_pkg::REG_PLOT_HEIGHT: prdata = 32'(plot_height_ff);
         wpd_pkg::REG_SCALE: prdata = 32'(scale_ff);
         wpd_pkg::REG_RESOLUTION: prdata = 32'(resolution_ff);
         wpd_pkg::REG_START_FRAME: prdata = 32'(start_frame_ff);
         default: prdata = '0;
      endcase
   end

   // Run state.
   wpd_pkg::state_type             state_ff, state_in;
   logic                           enabled_ff, enabled_in;
   logic [DIM_BITS-1:0]            column_ff, column_in;
   logic [PIX_W-1:0]               pixel_count_ff, pixel_count_in;
   logic [START_W-1:0]             frame_index_ff, frame_index_in;
   logic [CH_IDX_W-1:0]            channel_index_ff, channel_index_in;
   logic signed [SUM_W-1:0]        channel_sum_ff, channel_sum_in;
   logic [wpd_pkg::SCALE_W-1:0]    skip_count_ff, skip_count_in;
   logic                           eob_ff, eob_in;
   logic signed [SUM_W-1:0]        frame_sum_ff, frame_sum_in;
   logic [PIX_W-1:0]               inc_ff, inc_in;
   logic signed [AVG_W-1:0]        avg_ff, avg_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic [DIM_BITS-1:0]            y_ff, y_in;

   // Result register.
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_command_ff;
   logic [DIM_BITS-1:0]            rsp_pos_x_ff;
   logic [DIM_BITS-1:0]            rsp_pos_y_ff;
   logic                           rsp_last_ff;

   logic                           emit;
   logic [1:0]                     emit_cmd;
   logic [DIM_BITS-1:0]            emit_x;
   logic [DIM_BITS-1:0]            emit_y;
   logic                           emit_last;
   logic                           slot_free;

   // Divider interface.
   logic                           div_start;
   logic [SUM_W-1:0]               div_dividend;
   logic [RES_W-1:0]               div_divisor;
   wpd_pkg::div_status_type        div_status;
   logic [SUM_W-1:0]               div_quotient;

   // Derived values.
   logic [RES_W-1:0]               ch_wide;
   logic [RES_W-1:0]               nch;
   logic [wpd_pkg::SCALE_W-1:0]    sc;
   logic [RES_W-1:0]               rs;
   logic signed [SUM_W-1:0]        sample_val;
   logic signed [SUM_W-1:0]        sum_next;
   logic                           frame_done;
   logic [SUM_W-1:0]               sum_mag;
   logic [AVG_W-1:0]               avg_mag;
   logic [DIM_BITS-1:0]            half_height;
   logic [4:0]                     shift;
   logic signed [PROD_W-1:0]       bias;
   logic signed [PROD_W-1:0]       scaled;
   logic [PIX_W-1:0]               pix_sum;
   logic [DIM_BITS-1:0]            column_next;
   logic                           accept;

   assign ch_wide = RES_W'(channels_ff);
   assign nch = (channels_ff == '0) ? RES_W'(1) :
                (ch_wide > RES_W'(MAX_CHANNELS)) ? RES_W'(MAX_CHANNELS) : ch_wide;
   assign sc = (scale_ff == '0) ? wpd_pkg::SCALE_W'(1) : scale_ff;
   assign rs = (resolution_ff == '0) ? RES_W'(1) : resolution_ff;
   assign sample_val = sample_mode_ff ? SUM_W'($signed(req_sample)) :
                       SUM_W'($signed(req_sample[7:0] ^ 8'h80));
   assign sum_next = channel_sum_ff + sample_val;
   assign frame_done = (RES_W'(channel_index_ff) + RES_W'(1)) >= nch;
   assign sum_mag = frame_sum_ff[SUM_W-1] ? SUM_W'(-frame_sum_ff) : SUM_W'(frame_sum_ff);
   assign avg_mag = div_quotient[AVG_W-1:0];
   assign half_height = {1'b0, plot_height_ff[DIM_BITS-1:1]};
   assign shift = sample_mode_ff ? wpd_pkg::WIDE_SHIFT : wpd_pkg::NARROW_SHIFT;
   assign bias = prod_ff[PROD_W-1] ? ((PROD_W'(1) << shift) - PROD_W'(1)) : '0;
   assign scaled = (prod_ff + bias) >>> shift;
   assign pix_sum = pixel_count_ff + inc_ff;
   assign column_next = (pix_sum >= PIX_W'(sc)) ? column_ff + DIM_BITS'(1) : column_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == wpd_pkg::ST_IDLE);
   assign accept = req_valid && req_ready;

   assign div_dividend = (state_ff == wpd_pkg::ST_IDLE) ? SUM_W'(sc) : sum_mag;
   assign div_divisor = (state_ff == wpd_pkg::ST_IDLE) ? rs : nch;

   always_comb begin
      state_in = state_ff;
      enabled_in = enabled_ff;
      column_in = column_ff;
      pixel_count_in = pixel_count_ff;
      frame_index_in = frame_index_ff;
      channel_index_in = channel_index_ff;
      channel_sum_in = channel_sum_ff;
      skip_count_in = skip_count_ff;
      eob_in = eob_ff;
      frame_sum_in = frame_sum_ff;
      inc_in = inc_ff;
      avg_in = avg_ff;
      prod_in = prod_ff;
      y_in = y_ff;
      div_start = 1'b0;
      emit = 1'b0;
      emit_cmd = wpd_pkg::CMD_MOVE;
      emit_x = '0;
      emit_y = '0;
      emit_last = 1'b1;
      case (state_ff)
         wpd_pkg::ST_IDLE: begin
            if (accept) begin
               eob_in = req_end_of_buffer;
               if (!req_op) begin
                  column_in = '0;
                  pixel_count_in = '0;
                  frame_index_in = '0;
                  channel_index_in = '0;
                  channel_sum_in = '0;
                  skip_count_in = '0;
                  enabled_in = (plot_width_ff != '0) && (plot_height_ff != '0);
                  if ((plot_width_ff != '0) && (plot_height_ff != '0)) begin
                     state_in = wpd_pkg::ST_MOVE;
                  end
               end else if (enabled_ff) begin
                  state_in = req_end_of_buffer ? wpd_pkg::ST_FINISH : wpd_pkg::ST_IDLE;
                  if (frame_done) begin
                     channel_index_in = '0;
                     channel_sum_in = '0;
                     frame_sum_in = sum_next;
                     if (frame_index_ff < start_frame_ff) begin
                        frame_index_in = frame_index_ff + START_W'(1);
                     end else if (skip_count_ff == '0) begin
                        div_start = 1'b1;
                        state_in = wpd_pkg::ST_DIV_INC;
                     end else begin
                        skip_count_in = skip_count_ff - wpd_pkg::SCALE_W'(1);
                     end
                  end else begin
                     channel_index_in = channel_index_ff + CH_IDX_W'(1);
                     channel_sum_in = sum_next;
                  end
               end
            end
         end
         wpd_pkg::ST_DIV_INC: begin
            if (div_status.done) begin
               inc_in = PIX_W'(div_quotient[wpd_pkg::SCALE_W-1:0]) + PIX_W'(1);
               skip_count_in = div_quotient[wpd_pkg::SCALE_W-1:0];
               if (column_ff < plot_width_ff) begin
                  div_start = 1'b1;
                  state_in = wpd_pkg::ST_DIV_AVG;
               end else begin
                  state_in = eob_ff ? wpd_pkg::ST_FINISH : wpd_pkg::ST_IDLE;
               end
            end
         end
         wpd_pkg::ST_DIV_AVG: begin
            if (div_status.done) begin
               avg_in = frame_sum_ff[SUM_W-1] ? -$signed(avg_mag) : $signed(avg_mag);
               state_in = wpd_pkg::ST_MUL;
            end
         end
         wpd_pkg::ST_MUL: begin
            prod_in = PROD_W'(avg_ff) * PROD_W'($signed({1'b0, plot_height_ff}));
            state_in = wpd_pkg::ST_SCALE;
         end
         wpd_pkg::ST_SCALE: begin
            y_in = half_height + scaled[DIM_BITS-1:0];
            state_in = wpd_pkg::ST_LINE;
         end
         wpd_pkg::ST_LINE: begin
            if (slot_free) begin
               emit = 1'b1;
               emit_cmd = wpd_pkg::CMD_LINE;
               emit_x = column_ff;
               emit_y = y_ff;
               emit_last = !(eob_ff && (column_next < plot_width_ff));
               column_in = column_next;
               pixel_count_in = (pix_sum >= PIX_W'(sc)) ? '0 : pix_sum;
               state_in = eob_ff ? wpd_pkg::ST_FINISH : wpd_pkg::ST_IDLE;
            end
         end
         wpd_pkg::ST_FINISH: begin
            if (column_ff >= plot_width_ff) begin
               enabled_in = 1'b0;
               state_in = wpd_pkg::ST_IDLE;
            end else if (slot_free) begin
               emit = 1'b1;
               emit_cmd = wpd_pkg::CMD_FILL;
               emit_x = column_ff;
               enabled_in = 1'b0;
               state_in = wpd_pkg::ST_IDLE;
            end
         end
         wpd_pkg::ST_MOVE: begin
            if (slot_free) begin
               emit = 1'b1;
               emit_cmd = wpd_pkg::CMD_MOVE;
               emit_y = half_height;
               state_in = wpd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wpd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpd_pkg::ST_IDLE;
         enabled_ff <= 1'b0;
         column_ff <= '0;
         pixel_count_ff <= '0;
         frame_index_ff <= '0;
         channel_index_ff <= '0;
         channel_sum_ff <= '0;
         skip_count_ff <= '0;
         eob_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         enabled_ff <= enabled_in;
         column_ff <= column_in;
         pixel_count_ff <= pixel_count_in;
         frame_index_ff <= frame_index_in;
         channel_index_ff <= channel_index_in;
         channel_sum_ff <= channel_sum_in;
         skip_count_ff <= skip_count_in;
         eob_ff <= eob_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_sum_ff <= frame_sum_in;
      inc_ff <= inc_in;
      avg_ff <= avg_in;
      prod_ff <= prod_in;
      y_ff <= y_in;
      if (emit) begin
         rsp_command_ff <= emit_cmd;
         rsp_pos_x_ff <= emit_x;
         rsp_pos_y_ff <= emit_y;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_command = rsp_command_ff;
   assign rsp_pos_x = rsp_pos_x_ff;
   assign rsp_pos_y = rsp_pos_y_ff;
   assign rsp_last = rsp_last_ff;

   wpd_div #(
      .DIVIDEND_W(SUM_W),
      .DIVISOR_W(RES_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_dividend),
      .divisor(div_divisor),
      .status(div_status),
      .quotient(div_quotient)
   );

`ifndef SYNTHESIS
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == wpd_pkg::ST_DIV_INC || state_ff == wpd_pkg::ST_DIV_AVG))
      else $error("Divider finished outside a divide wait state.");

   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wpd_pkg::ST_IDLE) |-> !div_status.busy)
      else $error("Divider still busy while the sequencer accepts transactions.");

   a_fill_ends_render: assert property (@(posedge clock) disable iff (reset)
      (emit && emit_cmd == wpd_pkg::CMD_FILL) |=> !enabled_ff)
      else $error("Render still enabled after a fill result.");
`endif

endmodule

@@ test/tb_waveform_plot_decimator.sv @@
// Self-checking testbench for waveform_plot_decimator: drives start and sample transactions,
// programs the registers over the APB-style port and checks every plot command.
// Depends on wpd_pkg and the block's RTL.
module tb_waveform_plot_decimator;

   localparam logic OP_START = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;
   localparam int unsigned MAX_CHANNELS = 8;
   localparam int unsigned ITEM_TARGET = 1050;
   localparam int unsigned DRAIN_CYCLES = 120;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic        op;
      logic [15:0] sample;
      logic        eob;
   } pcm_word_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [11:0] pos_x;
      logic [11:0] pos_y;
      logic        last;
   } plot_cmd_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = 1'b0;
   logic [15:0] req_sample = '0;
   logic        req_end_of_buffer = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_command;
   logic [11:0] rsp_pos_x;
   logic [11:0] rsp_pos_y;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Register copies as seen by the predictor.
   logic [3:0]  cfg_channels = 4'd1;
   logic        cfg_mode = 1'b0;
   logic [11:0] cfg_width = '0;
   logic [11:0] cfg_height = '0;
   logic [15:0] cfg_scale = 16'd16;
   logic [7:0]  cfg_res = 8'd8;
   logic [23:0] cfg_start = '0;

   // Render state of the predictor.
   int unsigned column = 0;
   int unsigned pixel_count = 0;
   int unsigned frame_index = 0;
   int unsigned channel_index = 0;
   int          channel_sum = 0;
   int unsigned skip_count = 0;
   bit          render_active = 1'b0;

   pcm_word_type sample_queue[$];
   plot_cmd_type plot_expected[$];
   pcm_word_type next_word;
   plot_cmd_type seen_cmd;
   plot_cmd_type want_cmd;
   bit          word_in_flight = 1'b0;
   bit          no_idle = 1'b0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   int unsigned hold_at = 60;
   int unsigned idle_cycles = 0;
   int unsigned effective_items = 0;
   int unsigned commands_checked = 0;
   int unsigned settings_used = 0;
   int unsigned error_count = 0;

   waveform_plot_decimator i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_sample(req_sample), .req_end_of_buffer(req_end_of_buffer),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_command(rsp_command),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(15, 80);
   endfunction

   function automatic void push_plot(input logic [1:0] cmd, input logic [11:0] x,
                                     input logic [11:0] y, input logic is_last);
      plot_cmd_type c;
      c.command = cmd;
      c.pos_x = x;
      c.pos_y = y;
      c.last = is_last;
      plot_expected.push_back(c);
   endfunction

   // Returns 1 when the transaction is not simply ignored by the block.
   function automatic bit predict_plot(input logic op, input logic [15:0] raw, input logic eob);
      int unsigned nch;
      int unsigned sc;
      int unsigned rs;
      int unsigned step;
      int          v;
      int          sum;
      int          avg;
      longint      prod;
      longint      range;
      longint      yv;
      logic [11:0] line_x;
      logic [11:0] line_y;
      bit          drawn;
      drawn = 1'b0;
      line_x = '0;
      line_y = '0;
      if (op == OP_START) begin
         column = 0;
         pixel_count = 0;
         frame_index = 0;
         channel_index = 0;
         channel_sum = 0;
         skip_count = 0;
         render_active = (cfg_width != 0) && (cfg_height != 0);
         if (render_active)
            push_plot(wpd_pkg::CMD_MOVE, 12'd0, 12'(cfg_height / 2), 1'b1);
         return 1'b1;
      end
      if (!render_active) return 1'b0;
      nch = (cfg_channels == 0) ? 1 :
            ((cfg_channels > MAX_CHANNELS) ? MAX_CHANNELS : cfg_channels);
      sc = (cfg_scale == 0) ? 1 : cfg_scale;
      rs = (cfg_res == 0) ? 1 : cfg_res;
      step = sc / rs + 1;
      if (cfg_mode) v = {{16{raw[15]}}, raw};
      else v = int'({24'd0, raw[7:0]}) - 128;
      channel_sum += v;
      if (channel_index + 1 >= nch) begin
         sum = channel_sum;
         channel_index = 0;
         channel_sum = 0;
         if (frame_index < cfg_start) begin
            frame_index++;
         end else if (skip_count == 0) begin
            if (column < cfg_width) begin
               avg = sum / int'(nch);
               prod = longint'(avg) * longint'(cfg_height);
               range = cfg_mode ? 65536 : 256;
               yv = longint'(cfg_height / 2) + prod / range;
               line_x = column[11:0];
               line_y = yv[11:0];
               drawn = 1'b1;
               pixel_count += step;
               if (pixel_count >= sc) begin
                  column++;
                  pixel_count = 0;
               end
            end
            skip_count = step - 1;
         end else begin
            skip_count--;
         end
      end else begin
         channel_index++;
      end
      if (drawn) push_plot(wpd_pkg::CMD_LINE, line_x, line_y, !(eob && column < cfg_width));
      if (eob) begin
         if (column < cfg_width) push_plot(wpd_pkg::CMD_FILL, column[11:0], 12'd0, 1'b1);
         render_active = 1'b0;
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            void'(predict_plot(req_op, req_sample, req_end_of_buffer));
            effective_items++;
            word_in_flight = 1'b0;
         end
         if (!word_in_flight) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               next_word = sample_queue.pop_front();
               req_valid <= 1'b1;
               req_op <= next_word.op;
               req_sample <= next_word.sample;
               req_end_of_buffer <= next_word.eob;
               word_in_flight = 1'b1;
               gap_left = idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_cmd = {rsp_command, rsp_pos_x, rsp_pos_y, rsp_last};
            if (plot_expected.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected plot command: cmd %0d x %0d y %0d last %0b",
                           seen_cmd.command, seen_cmd.pos_x, seen_cmd.pos_y, seen_cmd.last);
            end else begin
               want_cmd = plot_expected.pop_front();
               if (seen_cmd !== want_cmd) begin
                  error_count++;
                  if (error_count <= 10)
                     $display({"plot command %0d: expected cmd %0d x %0d y %0d last %0b,",
                               " got cmd %0d x %0d y %0d last %0b"},
                              commands_checked, want_cmd.command, want_cmd.pos_x,
                              want_cmd.pos_y, want_cmd.last, seen_cmd.command,
                              seen_cmd.pos_x, seen_cmd.pos_y, seen_cmd.last);
               end
            end
            commands_checked++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (commands_checked >= hold_at) begin
            hold_left = HOLD_CYCLES;
            hold_at = (hold_at == 60) ? 700 : 32'hFFFF_FFFF;
            rsp_ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            stall_left = idle_length();
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d plot commands outstanding",
                  idle_cycles, plot_expected.size());
         $display("tb_waveform_plot_decimator: errors");
         $finish;
      end
   end

   task automatic csr_write(input logic [wpd_pkg::REG_IDX_W-1:0] idx, input logic [31:0] value);
      logic [31:0] readback;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      readback = '0;
      case (idx)
         wpd_pkg::REG_CHANNELS: begin
            cfg_channels = value[3:0];
            readback = {28'd0, value[3:0]};
         end
         wpd_pkg::REG_SAMPLE_MODE: begin
            cfg_mode = value[0];
            readback = {31'd0, value[0]};
         end
         wpd_pkg::REG_PLOT_WIDTH: begin
            cfg_width = value[11:0];
            readback = {20'd0, value[11:0]};
         end
         wpd_pkg::REG_PLOT_HEIGHT: begin
            cfg_height = value[11:0];
            readback = {20'd0, value[11:0]};
         end
         wpd_pkg::REG_SCALE: begin
            cfg_scale = value[15:0];
            readback = {16'd0, value[15:0]};
         end
         wpd_pkg::REG_RESOLUTION: begin
            cfg_res = value[7:0];
            readback = {24'd0, value[7:0]};
         end
         wpd_pkg::REG_START_FRAME: begin
            cfg_start = value[23:0];
            readback = {8'd0, value[23:0]};
         end
         default: ;
      endcase
      @(posedge clock);
      if (prdata !== readback) begin
         error_count++;
         if (error_count <= 10)
            $display("register %0d: expected read value %0h, got %0h", idx, readback, prdata);
      end
   endtask

   task automatic write_settings(input logic [3:0] ch, input logic mode, input logic [11:0] w,
                                 input logic [11:0] h, input logic [15:0] sc,
                                 input logic [7:0] rs, input logic [23:0] sf);
      csr_write(wpd_pkg::REG_CHANNELS, {28'd0, ch});
      csr_write(wpd_pkg::REG_SAMPLE_MODE, {31'd0, mode});
      csr_write(wpd_pkg::REG_PLOT_WIDTH, {20'd0, w});
      csr_write(wpd_pkg::REG_PLOT_HEIGHT, {20'd0, h});
      csr_write(wpd_pkg::REG_SCALE, {16'd0, sc});
      csr_write(wpd_pkg::REG_RESOLUTION, {24'd0, rs});
      csr_write(wpd_pkg::REG_START_FRAME, {8'd0, sf});
      settings_used++;
   endtask

   function automatic void queue_word(input logic op, input logic [15:0] sample, input logic eob);
      pcm_word_type w;
      w.op = op;
      w.sample = sample;
      w.eob = eob;
      sample_queue.push_back(w);
   endfunction

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4: return 16'h0080;
         5: return 16'h007F;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic wait_idle();
      while (sample_queue.size() != 0 || word_in_flight || plot_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase();
      logic [3:0]  ch;
      logic [11:0] w;
      logic [11:0] h;
      logic [15:0] sc;
      logic [7:0]  rs;
      logic [23:0] sf;
      int unsigned r;
      int unsigned nch;
      int unsigned frames;
      int unsigned words;
      int unsigned eob_at;
      int unsigned count;
      r = $urandom_range(0, 99);
      ch = 4'((r < 85) ? $urandom_range(1, 8) : ((r < 90) ? 0 : $urandom_range(9, 15)));
      r = $urandom_range(0, 99);
      w = 12'((r < 8) ? 0 : (r < 38) ? $urandom_range(1, 8) : (r < 80) ? $urandom_range(9, 500)
                                      : $urandom_range(4000, 4095));
      r = $urandom_range(0, 99);
      h = 12'((r < 6) ? 0 : (r < 16) ? 4095 : (r < 24) ? 1 : $urandom_range(1, 4095));
      r = $urandom_range(0, 99);
      sc = 16'((r < 40) ? $urandom_range(1, 4) : (r < 70) ? $urandom_range(1, 64)
                        : (r < 80) ? 16'hFFFF : (r < 90) ? 0 : $urandom);
      r = $urandom_range(0, 99);
      rs = 8'((r < 40) ? $urandom_range(1, 4) : (r < 60) ? $urandom_range(1, 255)
                       : (r < 70) ? 255 : (r < 80) ? 0 : $urandom_range(0, 255));
      r = $urandom_range(0, 99);
      sf = 24'((r < 60) ? 0 : (r < 85) ? $urandom_range(1, 4) : (r < 95) ? $urandom_range(5, 20)
                        : 24'hFFFFFF);
      write_settings(ch, 1'($urandom_range(0, 1)), w, h, sc, rs, sf);
      no_idle = ($urandom_range(0, 4) == 0);
      nch = (ch == 0) ? 1 : ((ch > MAX_CHANNELS) ? MAX_CHANNELS : ch);
      count = 0;
      while (count < 80) begin
         r = $urandom_range(0, 99);
         if (r < 78) begin
            frames = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
            words = frames * nch;
            queue_word(OP_START, rand_sample(), 1'($urandom_range(0, 1)));
            for (int unsigned k = 0; k < words; k++)
               queue_word(OP_SAMPLE, rand_sample(), k == words - 1);
            count += words + 1;
         end else if (r < 90) begin
            words = $urandom_range(1, 3 * nch + 2);
            eob_at = $urandom_range(0, words + 2);
            if ($urandom_range(0, 3) != 0) queue_word(OP_START, rand_sample(), 1'b0);
            for (int unsigned k = 0; k < words; k++)
               queue_word(OP_SAMPLE, rand_sample(), k == eob_at);
            count += words + 1;
         end else if (r < 95) begin
            words = $urandom_range(1, 3);
            for (int unsigned k = 0; k < words; k++)
               queue_word(OP_SAMPLE, rand_sample(), 1'($urandom_range(0, 1)));
            count += words;
         end else begin
            queue_word(OP_START, rand_sample(), 1'($urandom_range(0, 1)));
            count++;
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Eight-bit stereo: one skipped start frame, every second frame drawn, display
      // filling up, a partial frame at the end and a sample while idle.
      write_settings(4'd2, 1'b0, 12'd4, 12'd4095, 16'd1, 8'd1, 24'd1);
      queue_word(OP_START, 16'h0000, 1'b0);
      queue_word(OP_SAMPLE, 16'h1234, 1'b0);
      queue_word(OP_SAMPLE, 16'hABCD, 1'b0);
      queue_word(OP_SAMPLE, 16'h0000, 1'b0);
      queue_word(OP_SAMPLE, 16'h0000, 1'b0);
      queue_word(OP_SAMPLE, 16'h5555, 1'b0);
      queue_word(OP_SAMPLE, 16'hAAAA, 1'b0);
      queue_word(OP_SAMPLE, 16'h00FF, 1'b0);
      queue_word(OP_SAMPLE, 16'hFFFF, 1'b0);
      queue_word(OP_SAMPLE, 16'h0101, 1'b0);
      queue_word(OP_SAMPLE, 16'h0202, 1'b0);
      queue_word(OP_SAMPLE, 16'h0000, 1'b0);
      queue_word(OP_SAMPLE, 16'h0001, 1'b0);
      queue_word(OP_SAMPLE, 16'h3333, 1'b0);
      queue_word(OP_SAMPLE, 16'hCCCC, 1'b0);
      queue_word(OP_SAMPLE, 16'hFF80, 1'b0);
      queue_word(OP_SAMPLE, 16'hAB7F, 1'b0);
      queue_word(OP_SAMPLE, 16'h1111, 1'b1);
      queue_word(OP_SAMPLE, 16'h2222, 1'b1);
      wait_idle();

      // Sixteen-bit extremes at full size, a restart during a render and a line
      // followed by a fill from the same transaction.
      write_settings(4'd1, 1'b1, 12'd4095, 12'd4095, 16'hFFFF, 8'd255, 24'd0);
      queue_word(OP_START, 16'hFFFF, 1'b1);
      queue_word(OP_SAMPLE, 16'h8000, 1'b0);
      queue_word(OP_START, 16'h0000, 1'b0);
      queue_word(OP_SAMPLE, 16'h7FFF, 1'b1);
      wait_idle();

      // Zero width keeps the block idle.
      write_settings(4'd8, 1'b0, 12'd0, 12'd100, 16'd4, 8'd2, 24'd0);
      queue_word(OP_START, 16'h0000, 1'b0);
      queue_word(OP_SAMPLE, 16'h00FF, 1'b1);
      wait_idle();

      while (effective_items < ITEM_TARGET) random_phase();

      $display("Ran %0d start and sample transactions under %0d register settings.",
               effective_items, settings_used);
      $display("Checked %0d plot commands and every register write, %0d errors in total.",
               commands_checked, error_count);
      if (error_count == 0)
         $display("tb_waveform_plot_decimator: clean");
      else
         $display("tb_waveform_plot_decimator: errors");
      $finish;
   end
endmodule
